>>> design/bsv_pkg.sv
// shared types, character codes and result codes for the bencode stream validator
`default_nettype none

package bsv_pkg;

    // result status codes
    localparam logic [2:0] ST_PROGRESS = 3'd0;
    localparam logic [2:0] ST_DONE     = 3'd1;
    localparam logic [2:0] ST_SYNTAX   = 3'd2;
    localparam logic [2:0] ST_OVERFLOW = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_DISCARD  = 3'd5;

    // element kinds closed by a byte
    localparam logic [2:0] KIND_NONE = 3'd0;
    localparam logic [2:0] KIND_INT  = 3'd1;
    localparam logic [2:0] KIND_STR  = 3'd2;
    localparam logic [2:0] KIND_LIST = 3'd3;
    localparam logic [2:0] KIND_DICT = 3'd4;

    // container stack entries
    localparam logic [1:0] SK_LIST     = 2'd1;
    localparam logic [1:0] SK_DICT_KEY = 2'd2;
    localparam logic [1:0] SK_DICT_VAL = 2'd3;

    // grammar characters
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    // width of acc * 10 + digit
    localparam int ACC_EXT_W = 68;

    typedef struct packed {
        logic       push;
        logic [1:0] push_kind;
        logic       pop;
        logic       toggle;
        logic       clear;
    } stack_cmd_t;

    // a dictionary alternates between key and value after each element
    function automatic logic [1:0] stk_toggle(input logic [1:0] entry);
        logic [1:0] res;
        case (entry)
            SK_DICT_KEY: res = SK_DICT_VAL;
            SK_DICT_VAL: res = SK_DICT_KEY;
            default:     res = entry;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> design/bsv_stack.sv
// nesting stack: top entry in a register, lower entries in a synchronous memory
`default_nettype none

module bsv_stack
    import bsv_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               en,
    input  wire stack_cmd_t         cmd,
    output logic [DEPTH_W-1:0]      depth,
    output logic [1:0]              top
);

    localparam int ADDR_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

    logic [1:0]         mem [MAX_DEPTH];
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic [1:0]         top_reg;
    logic [1:0]         top_next;
    logic [1:0]         below_reg;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_ok;
    logic               rd_hit;

    always_comb
    begin
        depth_next = depth_reg;
        if (cmd.clear)
        begin
            depth_next = '0;
        end
        else if (cmd.push)
        begin
            depth_next = depth_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            depth_next = depth_reg - 1'b1;
        end

        top_next = top_reg;
        if (cmd.push)
        begin
            top_next = cmd.push_kind;
        end
        else if (cmd.pop)
        begin
            top_next = stk_toggle(below_reg);
        end
        else if (cmd.toggle)
        begin
            top_next = stk_toggle(top_reg);
        end

        // old top goes down into the memory on a push
        wr_en   = en && cmd.push && (depth_reg != '0);
        wr_addr = ADDR_W'(int'(depth_reg) - 1);
        // prefetch the entry below the new top
        rd_addr = ADDR_W'(int'(depth_next) - 2);
        rd_ok   = int'(depth_next) >= 2;
        rd_hit  = wr_en && (wr_addr == rd_addr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= '0;
        end
        else if (en)
        begin
            depth_reg <= depth_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= top_reg;
        end
        if (en && rd_ok)
        begin
            below_reg <= rd_hit ? top_reg : mem[rd_addr];
        end
        if (en)
        begin
            top_reg <= top_next;
        end
    end

    assign depth = depth_reg;
    assign top   = top_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("stack depth beyond limit");

    a_push_top: assert property (@(posedge clk) disable iff (!rst_n)
        en && cmd.push && !cmd.clear |=>
            top_reg == $past(cmd.push_kind) &&
            depth_reg == DEPTH_W'($past(depth_reg) + 1'b1))
        else $error("push did not land on top");

endmodule

`default_nettype wire

>>> design/bsv_core.sv
// per-byte grammar check, digit accumulation and stack commands
`default_nettype none

module bsv_core
    import bsv_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int LENGTH_BITS = 32,
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1)
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         data_byte,
    input  wire logic               end_of_buffer,
    input  wire logic [DEPTH_W-1:0] stack_depth,
    input  wire logic [1:0]         stack_top,
    output stack_cmd_t              cmd,
    output logic [2:0]              res_status,
    output logic [2:0]              res_kind,
    output logic signed [63:0]      res_ival,
    output logic [31:0]             res_slen
);

    localparam logic [2:0] PH_VALUE      = 3'd0;
    localparam logic [2:0] PH_INT_START  = 3'd1;
    localparam logic [2:0] PH_INT_SIGN   = 3'd2;
    localparam logic [2:0] PH_INT_DIGITS = 3'd3;
    localparam logic [2:0] PH_STR_LEN    = 3'd4;
    localparam logic [2:0] PH_STR_DATA   = 3'd5;
    localparam logic [2:0] PH_DISCARD    = 3'd6;
    localparam logic [2:0] PH_TRAIL      = 3'd7;

    logic [2:0]             phase_reg;
    logic [2:0]             phase_next;
    logic [63:0]            acc_reg;
    logic [63:0]            acc_next;
    logic [LENGTH_BITS-1:0] rem_reg;
    logic [LENGTH_BITS-1:0] rem_next;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic                   neg_reg;
    logic                   neg_next;

    logic [7:0]             dig;
    logic                   is_digit;
    logic [ACC_EXT_W-1:0]   prod;
    logic [ACC_EXT_W-1:0]   int_limit;
    logic                   int_ovf;
    logic                   len_ovf;
    logic                   depth_zero;
    logic                   depth_one;
    logic                   depth_full;
    logic [2:0]             err;
    logic                   top_done;
    logic [2:0]             st;

    always_comb
    begin
        dig      = data_byte - CH_0;
        is_digit = (data_byte >= CH_0) && (data_byte <= CH_9);
        // acc * 10 + digit as two shifts and adds
        prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1) + ACC_EXT_W'(dig[3:0]);
        int_limit = {4'b0, neg_reg, {63{~neg_reg}}};
        int_ovf   = prod > int_limit;
        len_ovf   = (prod >> LENGTH_BITS) != '0;
        rem_dec   = (rem_reg == '0) ? rem_reg : rem_reg - 1'b1;

        depth_zero = stack_depth == '0;
        depth_one  = stack_depth == DEPTH_W'(1);
        depth_full = stack_depth >= DEPTH_W'(MAX_DEPTH);

        phase_next = phase_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        cmd        = '0;
        err        = ST_PROGRESS;
        top_done   = 1'b0;
        st         = ST_PROGRESS;
        res_kind   = KIND_NONE;
        res_ival   = '0;
        res_slen   = '0;

        unique case (phase_reg)
            PH_VALUE:
            begin
                if (data_byte == CH_I)
                begin
                    phase_next = PH_INT_START;
                    acc_next   = '0;
                    neg_next   = 1'b0;
                end
                else if (is_digit)
                begin
                    acc_next   = 64'(dig[3:0]);
                    phase_next = PH_STR_LEN;
                end
                else if (data_byte == CH_L || data_byte == CH_D)
                begin
                    if (depth_full)
                    begin
                        err = ST_OVERFLOW;
                    end
                    else
                    begin
                        cmd.push      = 1'b1;
                        cmd.push_kind = (data_byte == CH_L) ? SK_LIST : SK_DICT_KEY;
                    end
                end
                else if (data_byte == CH_E && !depth_zero)
                begin
                    // a dictionary cannot close with its value still due
                    if (stack_top == SK_DICT_VAL)
                    begin
                        err = ST_SYNTAX;
                    end
                    else
                    begin
                        cmd.pop  = 1'b1;
                        res_kind = (stack_top == SK_LIST) ? KIND_LIST : KIND_DICT;
                        top_done = depth_one;
                    end
                end
                else
                begin
                    err = ST_SYNTAX;
                end
            end
            PH_INT_START, PH_INT_SIGN:
            begin
                if (phase_reg == PH_INT_START && data_byte == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = PH_INT_SIGN;
                end
                else if (is_digit)
                begin
                    acc_next   = 64'(dig[3:0]);
                    phase_next = PH_INT_DIGITS;
                end
                else
                begin
                    err = ST_SYNTAX;
                end
            end
            PH_INT_DIGITS:
            begin
                if (is_digit)
                begin
                    if (int_ovf)
                    begin
                        err = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = prod[63:0];
                    end
                end
                else if (data_byte == CH_E)
                begin
                    res_kind   = KIND_INT;
                    res_ival   = neg_reg ? 64'(64'd0 - acc_reg) : acc_reg;
                    phase_next = PH_VALUE;
                    top_done   = depth_zero;
                    cmd.toggle = !depth_zero;
                end
                else
                begin
                    err = ST_SYNTAX;
                end
            end
            PH_STR_LEN:
            begin
                if (is_digit)
                begin
                    if (len_ovf)
                    begin
                        err = ST_OVERFLOW;
                    end
                    else
                    begin
                        acc_next = prod[63:0];
                    end
                end
                else if (data_byte == CH_COLON)
                begin
                    if (acc_reg == '0)
                    begin
                        // empty string closes at the colon
                        res_kind   = KIND_STR;
                        phase_next = PH_VALUE;
                        top_done   = depth_zero;
                        cmd.toggle = !depth_zero;
                    end
                    else
                    begin
                        rem_next   = LENGTH_BITS'(acc_reg);
                        phase_next = PH_STR_DATA;
                    end
                end
                else
                begin
                    err = ST_SYNTAX;
                end
            end
            PH_STR_DATA:
            begin
                rem_next = rem_dec;
                if (rem_dec == '0)
                begin
                    res_kind   = KIND_STR;
                    res_slen   = 32'(acc_reg);
                    phase_next = PH_VALUE;
                    top_done   = depth_zero;
                    cmd.toggle = !depth_zero;
                end
            end
            PH_DISCARD, PH_TRAIL:
            begin
                st = ST_DISCARD;
            end
        endcase

        if (err != ST_PROGRESS)
        begin
            st         = err;
            res_kind   = KIND_NONE;
            res_ival   = '0;
            res_slen   = '0;
            phase_next = PH_DISCARD;
            acc_next   = '0;
            rem_next   = '0;
            neg_next   = 1'b0;
            cmd        = '0;
            cmd.clear  = 1'b1;
        end
        else if (top_done)
        begin
            st         = ST_DONE;
            phase_next = PH_TRAIL;
        end

        if (end_of_buffer)
        begin
            if (st == ST_PROGRESS)
            begin
                st = ST_TRUNC;
            end
            phase_next = PH_VALUE;
            acc_next   = '0;
            rem_next   = '0;
            neg_next   = 1'b0;
            cmd.clear  = 1'b1;
        end

        res_status = st;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_VALUE;
            acc_reg   <= '0;
            rem_reg   <= '0;
            neg_reg   <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            neg_reg   <= neg_next;
        end
    end

endmodule

`default_nettype wire

>>> design/bencode_stream_validator_unit.sv
// top level: bencode stream validator with output register
// a result appears on out_valid in the cycle after its byte is accepted
// throughput: one byte per cycle unless in_stall; the stack memory prefetches the entry
//   below the top, so a close followed directly by another close needs no wait
// reset: rst_n (async, active low) clears parse phase, accumulators, depth and out_valid
// the stack memory is not cleared; entries are written before they are read
`default_nettype none

module bencode_stream_validator_unit
    import bsv_pkg::*;
#(
    parameter int MAX_DEPTH = 32,
    parameter int LENGTH_BITS = 32
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    data_byte,
    input  wire logic          end_of_buffer,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [2:0]         status,
    output logic [2:0]         token_kind,
    output logic signed [63:0] integer_value,
    output logic [31:0]        string_length,
    output logic [5:0]         nesting_depth
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    logic               step;
    stack_cmd_t         cmd;
    logic [DEPTH_W-1:0] stack_depth;
    logic [1:0]         stack_top;
    logic [2:0]         res_status;
    logic [2:0]         res_kind;
    logic signed [63:0] res_ival;
    logic [31:0]        res_slen;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [2:0]         status_reg;
    logic [2:0]         kind_reg;
    logic signed [63:0] ival_reg;
    logic [31:0]        slen_reg;

    // a new request enters whenever the output register is empty or being drained
    assign in_stall = out_valid_reg && out_stall;
    assign step     = in_valid && !in_stall;

    bsv_core #(
        .MAX_DEPTH   (MAX_DEPTH),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .stack_depth   (stack_depth),
        .stack_top     (stack_top),
        .cmd           (cmd),
        .res_status    (res_status),
        .res_kind      (res_kind),
        .res_ival      (res_ival),
        .res_slen      (res_slen)
    );

    bsv_stack #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_stack (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (step),
        .cmd   (cmd),
        .depth (stack_depth),
        .top   (stack_top)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            status_reg <= res_status;
            kind_reg   <= res_kind;
            ival_reg   <= res_ival;
            slen_reg   <= res_slen;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign token_kind    = kind_reg;
    assign integer_value = ival_reg;
    assign string_length = slen_reg;
    // depth only moves together with the output register
    assign nesting_depth = 6'(stack_depth);

    a_done_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_DONE |-> nesting_depth == 6'd0)
        else $error("top value done with containers still open");

    a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_SYNTAX || status == ST_OVERFLOW) |->
            token_kind == KIND_NONE && integer_value == '0 && string_length == '0)
        else $error("error result carries element data");

endmodule

`default_nettype wire
